// ===== sv/bra_pkg.sv =====
// Shared types and constants for the bounded rational approximation block.
// Used by bra_cmp_unit, bounded_rational_approximation and the testbench.
// No dependencies.
package bra_pkg;

	localparam int FRAC_BITS = 16;
	localparam int VAL_W     = 32;              // width of value_fixed
	localparam int INT_W     = VAL_W - FRAC_BITS;
	localparam int DEN_W     = 17;              // working denominators, up to twice the limit
	localparam int NUM_W     = 35;              // working numerators
	localparam int PROD_W    = NUM_W + FRAC_BITS;
	localparam int OUT_NUM_W = 33;
	localparam int OUT_DEN_W = 16;
	localparam int CFG_W     = 16;
	localparam int TDATA_O_W = 56;

	localparam logic [CFG_W-1:0] MAX_DEN_RESET = 16'd256;
	localparam logic             REG_MAX_DEN   = 1'b0;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CHK  = 4'b0010,
		ST_CMP  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	typedef struct packed {
		logic eq;
		logic gt;
	} cmp_res_t;

endpackage

// ===== sv/bra_cmp_unit.sv =====
// Shared multiply-and-compare unit: registers value*md and mn*2^FRAC_BITS,
// then compares the two registered terms exactly.
// Depends on bra_pkg.
module bra_cmp_unit (
	input  logic                         clk,
	input  logic                         en,
	input  logic [bra_pkg::VAL_W-1:0]    value,
	input  logic [bra_pkg::DEN_W-1:0]    md,
	input  logic [bra_pkg::NUM_W-1:0]    mn,
	output bra_pkg::cmp_res_t            res
);

	logic [bra_pkg::PROD_W-1:0] lhs_q;
	logic [bra_pkg::PROD_W-1:0] rhs_q;
	logic [bra_pkg::VAL_W+bra_pkg::DEN_W-1:0] prod;

	assign prod = {{bra_pkg::DEN_W{1'b0}}, value} * {{bra_pkg::VAL_W{1'b0}}, md};

	always_ff @(posedge clk) begin
		if (en) begin
			lhs_q <= bra_pkg::PROD_W'(prod);
			rhs_q <= {mn, {bra_pkg::FRAC_BITS{1'b0}}};
		end
	end

	assign res.eq = (lhs_q == rhs_q);
	assign res.gt = (lhs_q > rhs_q);

endmodule

// ===== sv/bounded_rational_approximation.sv =====
// Top level: APB register, stream ports and the Stern-Brocot step sequencer.
// Depends on bra_pkg and bra_cmp_unit.
//
//  channel  | direction | beat carries
//  s_axis   | in        | value_fixed[31:0]
//  m_axis   | out       | numerator[32:0], denominator[48:33], zero pad [55:49]
//  apb      | in/out    | max_denominator at byte address 0
//
// An item is loaded in IDLE; each mediant step runs CHK (multiply in the
// shared unit) and then CMP (compare), one more CHK ends the walk when it runs
// out of room, and FIN hands over the result; each step raises a denominator
// by one or more.
// The input is not ready while a walk runs.
// The output register holds a finished beat, so a new item is taken while it
// waits; a second finished result stalls the sequencer until the first leaves.
// Reset is asynchronous and clears control state and max_denominator to 256.
module bounded_rational_approximation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // value_fixed[31:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // numerator[32:0], denominator[48:33], zero
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [bra_pkg::CFG_W-1:0] max_den_q;
	bra_pkg::state_t           state_q;

	logic [bra_pkg::VAL_W-1:0] value_q;
	logic [bra_pkg::NUM_W-1:0] a_q, c_q, mn_q;
	logic [bra_pkg::DEN_W-1:0] b_q, d_q, md_q;
	logic [bra_pkg::NUM_W-1:0] p_q;
	logic [bra_pkg::DEN_W-1:0] q_q;

	logic                          out_valid_q;
	logic [bra_pkg::OUT_NUM_W-1:0] out_num_q;
	logic [bra_pkg::OUT_DEN_W-1:0] out_den_q;

	logic [bra_pkg::DEN_W-1:0] lim;
	logic [bra_pkg::NUM_W-1:0] mn_c;
	logic [bra_pkg::DEN_W-1:0] md_c;
	logic                      in_range;
	logic                      unit_en;
	logic                      out_free;
	bra_pkg::cmp_res_t         cmp;

	// APB
	assign pready = 1'b1;
	assign prdata = (paddr[2] == bra_pkg::REG_MAX_DEN) ? {16'd0, max_den_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_den_q <= bra_pkg::MAX_DEN_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == bra_pkg::REG_MAX_DEN) begin
			max_den_q <= pwdata[bra_pkg::CFG_W-1:0];
		end
	end

	// A limit of zero behaves as one.
	assign lim = (max_den_q == '0) ? bra_pkg::DEN_W'(1)
	                               : {1'b0, max_den_q};

	assign mn_c     = a_q + c_q;
	assign md_c     = b_q + d_q;
	assign in_range = (b_q <= lim) && (d_q <= lim);
	assign unit_en  = (state_q == bra_pkg::ST_CHK);
	assign out_free = !out_valid_q || m_axis_tready;

	bra_cmp_unit u_cmp (
		.clk   (clk),
		.en    (unit_en),
		.value (value_q),
		.md    (md_c),
		.mn    (mn_c),
		.res   (cmp)
	);

	assign s_axis_tready = (state_q == bra_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bra_pkg::ST_IDLE;
		end else begin
			unique case (state_q)
				bra_pkg::ST_IDLE: if (s_axis_tvalid) state_q <= bra_pkg::ST_CHK;
				bra_pkg::ST_CHK:  state_q <= in_range ? bra_pkg::ST_CMP : bra_pkg::ST_FIN;
				bra_pkg::ST_CMP:  state_q <= cmp.eq ? bra_pkg::ST_FIN : bra_pkg::ST_CHK;
				bra_pkg::ST_FIN:  if (out_free) state_q <= bra_pkg::ST_IDLE;
				default:          state_q <= bra_pkg::ST_IDLE;
			endcase
		end
	end

	// Walk registers carry payload only.
	always_ff @(posedge clk) begin
		unique case (state_q)
			bra_pkg::ST_IDLE: begin
				value_q <= s_axis_tdata;
				a_q     <= bra_pkg::NUM_W'(s_axis_tdata[bra_pkg::VAL_W-1:bra_pkg::FRAC_BITS]);
				c_q     <= bra_pkg::NUM_W'(s_axis_tdata[bra_pkg::VAL_W-1:bra_pkg::FRAC_BITS])
				           + bra_pkg::NUM_W'(1);
				b_q     <= bra_pkg::DEN_W'(1);
				d_q     <= bra_pkg::DEN_W'(1);
			end
			bra_pkg::ST_CHK: begin
				mn_q <= mn_c;
				md_q <= md_c;
				// Walk ran out of room: take the bound that still fits.
				if (b_q > lim) begin
					p_q <= c_q;
					q_q <= d_q;
				end else begin
					p_q <= a_q;
					q_q <= b_q;
				end
			end
			bra_pkg::ST_CMP: begin
				priority if (cmp.eq) begin
					// Exact hit: the mediant if it fits, else the bound with the
					// larger denominator, the lower one on a tie.
					if (md_q <= lim) begin
						p_q <= mn_q;
						q_q <= md_q;
					end else if (d_q > b_q) begin
						p_q <= c_q;
						q_q <= d_q;
					end else begin
						p_q <= a_q;
						q_q <= b_q;
					end
				end else if (cmp.gt) begin
					a_q <= mn_q;
					b_q <= md_q;
				end else begin
					c_q <= mn_q;
					d_q <= md_q;
				end
			end
			bra_pkg::ST_FIN: begin
			end
			default: begin
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == bra_pkg::ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == bra_pkg::ST_FIN && out_free) begin
			out_num_q <= p_q[bra_pkg::OUT_NUM_W-1:0];
			out_den_q <= q_q[bra_pkg::OUT_DEN_W-1:0];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(bra_pkg::TDATA_O_W-bra_pkg::OUT_NUM_W-bra_pkg::OUT_DEN_W){1'b0}},
	                        out_den_q, out_num_q};

endmodule

// ===== sv/bra_checker.sv =====
// Port-level checks for bounded_rational_approximation, attached by bind.
// Uses no package.
module bra_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [55:0] m_axis_tdata,
	input logic        pready
);

	// A stalled result beat holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// Every result has a denominator of at least one.
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[48:33] != 16'd0)
		else $error("zero denominator");

	// Padding above the denominator stays clear.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[55:49] == 7'd0)
		else $error("padding bits set");

	// Once an item is taken the walk runs, so the input closes.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input still ready after a beat was taken");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

endmodule

bind bounded_rational_approximation bra_checker u_bra_checker (.*);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for bounded_rational_approximation: drives value beats, writes
// max_denominator over APB and checks every result against its own Stern-Brocot walk.
// Depends on bra_pkg and the bounded_rational_approximation RTL.
module testbench;

	localparam longint     CYCLE_LIMIT  = 64'd25_000_000;
	localparam logic [2:0] ADDR_MAX_DEN = {bra_pkg::REG_MAX_DEN, 2'b00};
	localparam int         HOLD_AT_BEAT = 300;
	localparam int         HOLD_CYCLES  = 600;

	typedef struct packed {
		logic [bra_pkg::OUT_NUM_W-1:0] num;
		logic [bra_pkg::OUT_DEN_W-1:0] den;
	} frac_t;

	class fraction_scoreboard;
		frac_t                     expected_fracs[$];
		logic [bra_pkg::CFG_W-1:0] max_den;
		int                        errors;

		function new();
			max_den = bra_pkg::MAX_DEN_RESET;
			errors  = 0;
		endfunction

		task report(input string what);
			if (errors < 100) begin
				$display("MISMATCH @%0t: %s", $time, what);
			end
			errors++;
		endtask

		// Walk the tree between floor(x)/1 and (floor(x)+1)/1 with exact integer compares.
		function frac_t best_fraction(input logic [bra_pkg::VAL_W-1:0] v_in);
			logic [63:0] v, lim, a, b, c, d, mn, md, lhs, rhs, p, q;
			bit          hit;
			frac_t       res;
			v   = 64'(v_in) & ((64'd1 << (bra_pkg::INT_W + bra_pkg::FRAC_BITS)) - 64'd1);
			lim = (max_den == '0) ? 64'd1 : 64'(max_den);
			a   = v >> bra_pkg::FRAC_BITS;
			b   = 64'd1;
			c   = a + 64'd1;
			d   = 64'd1;
			p   = a;
			q   = b;
			hit = 1'b0;
			while (!hit && b <= lim && d <= lim) begin
				mn  = a + c;
				md  = b + d;
				lhs = v * md;
				rhs = mn << bra_pkg::FRAC_BITS;
				if (lhs == rhs) begin
					hit = 1'b1;
					if (md <= lim) begin
						p = mn;
						q = md;
					end else if (d > b) begin
						p = c;
						q = d;
					end else begin
						p = a;
						q = b;
					end
				end else if (lhs > rhs) begin
					a = mn;
					b = md;
				end else begin
					c = mn;
					d = md;
				end
			end
			if (!hit) begin
				if (b > lim) begin
					p = c;
					q = d;
				end else begin
					p = a;
					q = b;
				end
			end
			res.num = p[bra_pkg::OUT_NUM_W-1:0];
			res.den = q[bra_pkg::OUT_DEN_W-1:0];
			return res;
		endfunction

		function void note_value(input logic [bra_pkg::VAL_W-1:0] v);
			expected_fracs.insert(expected_fracs.size(), best_fraction(v));
		endfunction

		task check_fraction(input logic [bra_pkg::TDATA_O_W-1:0] beat);
			frac_t want;
			if (expected_fracs.size() == 0) begin
				report($sformatf("result beat %h with nothing outstanding", beat));
			end else begin
				want = expected_fracs.pop_front();
				if (beat[bra_pkg::OUT_NUM_W-1:0] !== want.num) begin
					report($sformatf("numerator %0d, expected %0d",
						beat[bra_pkg::OUT_NUM_W-1:0], want.num));
				end
				if (beat[bra_pkg::OUT_NUM_W+bra_pkg::OUT_DEN_W-1:bra_pkg::OUT_NUM_W]
						!== want.den) begin
					report($sformatf("denominator %0d, expected %0d",
						beat[bra_pkg::OUT_NUM_W+bra_pkg::OUT_DEN_W-1:bra_pkg::OUT_NUM_W],
						want.den));
				end
				if (beat[bra_pkg::TDATA_O_W-1:bra_pkg::OUT_NUM_W+bra_pkg::OUT_DEN_W] !== '0) begin
					report($sformatf("pad bits %b not zero",
						beat[bra_pkg::TDATA_O_W-1:bra_pkg::OUT_NUM_W+bra_pkg::OUT_DEN_W]));
				end
			end
		endtask
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_axis_tvalid = 1'b0;
	logic                          s_axis_tready;
	logic [bra_pkg::VAL_W-1:0]     s_axis_tdata = '0;
	logic                          m_axis_tvalid;
	logic                          m_axis_tready = 1'b0;
	logic [bra_pkg::TDATA_O_W-1:0] m_axis_tdata;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [2:0]                    paddr = '0;
	logic [31:0]                   pwdata = '0;
	logic [31:0]                   prdata;
	logic                          pready;

	fraction_scoreboard            sb = new();
	bit                            rx_idle = 1'b1;
	int                            rx_beats = 0;
	longint                        cycles = 0;
	logic [bra_pkg::VAL_W-1:0]     edge_values[$];
	int                            phase_lims[$];
	int                            phase_counts[$];

	bounded_rational_approximation u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("bounded_rational_approximation verification failed");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Deep walks (near-integers, fine dyadics, near simple fractions) only where the
	// limit keeps them short.
	function automatic logic [bra_pkg::VAL_W-1:0] draw_value(input bit deep_ok);
		int          r, k, s, p, q;
		logic [15:0] ip, fp;
		r  = $urandom_range(0, 9);
		ip = 16'($urandom);
		fp = 16'($urandom);
		if (r == 4) begin
			fp = '0;
		end else if (r == 5 && deep_ok) begin
			k  = $urandom_range(1, 15);
			fp = $urandom_range(0, 1) ? 16'(k) : 16'(65536 - k);
		end else if (r == 6 || r == 7) begin
			k  = $urandom_range(1, 255);
			s  = deep_ok ? $urandom_range(0, 15) : $urandom_range(8, 15);
			fp = 16'(k << s);
		end else if (r >= 8 && deep_ok) begin
			q  = $urandom_range(2, 24);
			p  = $urandom_range(1, q - 1);
			fp = 16'((p * 65536) / q + $urandom_range(0, 4) - 2);
		end
		return {ip, fp};
	endfunction

	task automatic send_value(input logic [bra_pkg::VAL_W-1:0] v, input bit idle);
		int gap;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= v;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_value(v);
		gap = idle ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic reg_read(output logic [31:0] rd);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_MAX_DEN;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// The upper half of pwdata carries junk, which the register must drop.
	task automatic reg_write(input logic [bra_pkg::CFG_W-1:0] val);
		logic [31:0] rd;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_MAX_DEN;
		pwdata  <= {16'($urandom), val};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		sb.max_den = val;
		reg_read(rd);
		if (rd[bra_pkg::CFG_W-1:0] !== val)
			sb.report($sformatf("max_denominator reads %0d, wrote %0d",
				rd[bra_pkg::CFG_W-1:0], val));
	endtask

	// Every item gives exactly one result, so the block is idle once nothing is outstanding.
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.expected_fracs.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Result side: random back-pressure, plus one long hold-off to fill the block up.
	initial begin
		int stall;
		stall = 0;
		forever begin
			@(negedge clk);
			m_axis_tready <= (stall == 0);
			if (stall > 0)
				stall--;
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				sb.check_fraction(m_axis_tdata);
				rx_beats++;
				stall = rx_idle ? pick_gap() : 0;
				if (rx_beats == HOLD_AT_BEAT)
					stall = HOLD_CYCLES;
			end
		end
	end

	initial begin
		logic [31:0] rd;
		bit          tx_idle;
		edge_values = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0005_0000, 32'hFFFF_0000,
			32'h0000_8000, 32'h0000_C000, 32'h0000_4000, 32'h0001_0001,
			32'h0001_FFFF, 32'h0000_5555, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h0000_2000, 32'h0000_AAAB, 32'h0000_0001};
		phase_lims   = '{256, 1, 0, 2, 7, 31, 100, 1000, 4095, 65535};
		phase_counts = '{250, 100, 50, 80, 120, 50, 170, 150, 60, 12};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		reg_read(rd);
		if (rd[bra_pkg::CFG_W-1:0] !== bra_pkg::MAX_DEN_RESET)
			sb.report($sformatf("max_denominator resets to %0d", rd[bra_pkg::CFG_W-1:0]));

		// A limit of three separates the exact-hit cases: fits, upper bound, lower bound.
		reg_write(16'd3);
		foreach (edge_values[i])
			send_value(edge_values[i], 1'b1);
		settle();

		foreach (phase_lims[ph]) begin
			reg_write(bra_pkg::CFG_W'(phase_lims[ph]));
			rx_idle = ($urandom_range(0, 3) != 0);
			tx_idle = ($urandom_range(0, 3) != 0);
			// Just above an integer the walk runs to the full limit.
			if (phase_lims[ph] == 65535)
				send_value(32'h0003_0001, tx_idle);
			repeat (phase_counts[ph])
				send_value(draw_value(phase_lims[ph] <= 4095), tx_idle);
			settle();
		end

		repeat (20) @(posedge clk);
		if (sb.errors == 0) begin
			$display("bounded_rational_approximation verification clean");
		end else begin
			$display("bounded_rational_approximation verification failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
sv/bra_pkg.sv
sv/bra_cmp_unit.sv
sv/bounded_rational_approximation.sv
sv/bra_checker.sv
verif/testbench.sv
